@@ rtl/assert_macros.svh @@
// assertion macros shared by the d8 flow direction rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define D8FD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define D8FD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/d8fd_pkg.sv @@
// types and constants of the d8 flow direction block
// no dependencies
`default_nettype none

package d8fd_pkg;

  localparam int ELEV_BITS   = 16;
  localparam int SLOT_W      = 16;
  localparam int NBR         = 8;
  localparam int DROP_W      = ELEV_BITS + 1;
  localparam int ORTHO_SHIFT = 16;
  localparam int KEY_W       = DROP_W + ORTHO_SHIFT;
  localparam int DIR_W       = 4;

  // 1/sqrt(2) in q16, rounded
  localparam logic [ORTHO_SHIFT-1:0] DIAG_SCALE = ORTHO_SHIFT'(46341);

  localparam logic [DIR_W-1:0] DIR_NONE  = '0;
  localparam logic [DIR_W-1:0] DIR_FIRST = DIR_W'(1);
  localparam logic [DIR_W-1:0] DIR_LAST  = DIR_W'(NBR);

  localparam logic MODE_STEEP  = 1'b0;
  localparam logic MODE_WEIGHT = 1'b1;

  // one contender in the selection tree
  typedef struct packed {
    logic                    vld;
    logic signed [KEY_W-1:0] key;
    logic [DIR_W-1:0]        dir;
  } cand_t;

endpackage

`default_nettype wire

@@ rtl/d8fd_pick.sv @@
// one node of the selection tree: larger key wins, a wins ties
// depends on d8fd_pkg
`default_nettype none

module d8fd_pick (
  input  var d8fd_pkg::cand_t a_i,
  input  var d8fd_pkg::cand_t b_i,
  output d8fd_pkg::cand_t     y_o
);

  always_comb begin
    if (!a_i.vld) begin
      y_o = b_i;
    end else if (b_i.vld && (b_i.key > a_i.key)) begin
      y_o = b_i;
    end else begin
      y_o = a_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/d8_flow_direction_top.sv @@
// top level of the d8 flow direction block: four-stage pipeline
// depends on d8fd_pkg, d8fd_pick and assert_macros.svh
`default_nettype none

// d8 drainage direction for one 3x3 elevation window per transfer.
// an item passes from input transfer to result through the registered stages
// in order (stage 1 drops and overrides, stage 2 slope or weight keys with the
// 1/sqrt(2) multiply, stage 3 first tree level, stage 4 last two tree levels
// into the output register). one item is accepted every cycle unless a stall
// at the output has filled every stage; the rate is set by the elastic valid chain.
// a stall at the output freezes only the stages that are full, so bubbles
// close up and nothing is dropped or repeated.
// forced_dir 1..8 passes through with was_forced set; otherwise the first
// neighbour off the grid wins; otherwise route_mode selects steepest descent
// (earliest neighbour on a tie, uphill allowed) or highest weight among
// downslope neighbours (0 when there is none).
// route_mode is written through cfg_we_i / cfg_data_i and should only be
// changed while the pipeline is empty.
module d8_flow_direction_top (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // configuration
  input  wire                                cfg_we_i,
  input  wire                                cfg_data_i,
  // input channel
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  wire signed [15:0]                  center_elev_i,
  input  wire [63:0]                         nbr_elev_lo_i,
  input  wire [63:0]                         nbr_elev_hi_i,
  input  wire [63:0]                         nbr_weight_lo_i,
  input  wire [63:0]                         nbr_weight_hi_i,
  input  wire [7:0]                          nbr_in_grid_i,
  input  wire [7:0]                          forced_dir_i,
  // output channel
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic [3:0]                         flow_dir_o,
  output logic                               was_forced_o
);

  localparam int NBR    = d8fd_pkg::NBR;
  localparam int DROP_W = d8fd_pkg::DROP_W;
  localparam int KEY_W  = d8fd_pkg::KEY_W;
  localparam int DIR_W  = d8fd_pkg::DIR_W;
  localparam int ELEV_B = d8fd_pkg::ELEV_BITS;
  localparam int SLOT_W = d8fd_pkg::SLOT_W;
  localparam int OSH    = d8fd_pkg::ORTHO_SHIFT;

  // configuration register
  logic route_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      route_mode_q <= d8fd_pkg::MODE_STEEP;
    end else if (cfg_we_i) begin
      route_mode_q <= cfg_data_i;
    end
  end

  // elastic stage control: a stage moves when it is empty or the next one moves
  logic v1_q, v2_q, v3_q, v4_q;
  logic adv1, adv2, adv3, adv4;

  assign adv4       = !v4_q || out_ready_i;
  assign adv3       = !v3_q || adv4;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_ready_o = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: drops, weights, override decision
  // ---------------------------------------------------------------------
  logic signed [DROP_W-1:0] center_ext;
  logic signed [DROP_W-1:0] drop_d [NBR];
  logic [SLOT_W-1:0]        wgt_d  [NBR];
  logic signed [DROP_W-1:0] drop_q [NBR];
  logic [SLOT_W-1:0]        wgt_q  [NBR];

  logic             pre_sel_d, pre_sel_q;   // result settled before the search
  logic [DIR_W-1:0] pre_dir_d, pre_dir_q;
  logic             forced_d, forced_q;

  assign center_ext = DROP_W'(signed'(center_elev_i[ELEV_B-1:0]));

  for (genvar k = 0; k < NBR; k++) begin : g_drop
    logic [SLOT_W-1:0] elev_slot;
    if (k < NBR / 2) begin : g_lo
      assign elev_slot = nbr_elev_lo_i[SLOT_W*k +: SLOT_W];
      assign wgt_d[k]  = nbr_weight_lo_i[SLOT_W*k +: SLOT_W];
    end else begin : g_hi
      assign elev_slot = nbr_elev_hi_i[SLOT_W*(k-NBR/2) +: SLOT_W];
      assign wgt_d[k]  = nbr_weight_hi_i[SLOT_W*(k-NBR/2) +: SLOT_W];
    end
    assign drop_d[k] = center_ext - DROP_W'(signed'(elev_slot[ELEV_B-1:0]));
  end

  // forced route first, then the first neighbour off the grid
  always_comb begin
    logic             off_hit;
    logic [DIR_W-1:0] off_dir;
    off_hit = 1'b0;
    off_dir = d8fd_pkg::DIR_NONE;
    for (int k = NBR - 1; k >= 0; k--) begin
      if (!nbr_in_grid_i[k]) begin
        off_hit = 1'b1;
        off_dir = DIR_W'(k + 1);
      end
    end
    forced_d = forced_dir_i inside {[8'(d8fd_pkg::DIR_FIRST):8'(d8fd_pkg::DIR_LAST)]};
    if (forced_d) begin
      pre_sel_d = 1'b1;
      pre_dir_d = forced_dir_i[DIR_W-1:0];
    end else begin
      pre_sel_d = off_hit;
      pre_dir_d = off_dir;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      drop_q    <= drop_d;
      wgt_q     <= wgt_d;
      pre_sel_q <= pre_sel_d;
      pre_dir_q <= pre_dir_d;
      forced_q  <= forced_d;
    end
  end

  // ---------------------------------------------------------------------
  // stage 2: per-neighbour key (slope score or weight)
  // ---------------------------------------------------------------------
  d8fd_pkg::cand_t  cand2_d [NBR];
  d8fd_pkg::cand_t  cand2_q [NBR];
  logic             pre_sel2_q, forced2_q;
  logic [DIR_W-1:0] pre_dir2_q;

  for (genvar k = 0; k < NBR; k++) begin : g_key
    logic signed [KEY_W:0]   diag_prod;
    logic signed [KEY_W-1:0] score;
    // odd directions (even index) are diagonals
    assign diag_prod = drop_q[k] * signed'({1'b0, d8fd_pkg::DIAG_SCALE});
    if ((k % 2) == 0) begin : g_diag
      assign score = diag_prod[KEY_W-1:0];
    end else begin : g_orth
      assign score = {drop_q[k], {OSH{1'b0}}};
    end
    always_comb begin
      cand2_d[k].dir = DIR_W'(k + 1);
      if (route_mode_q == d8fd_pkg::MODE_WEIGHT) begin
        cand2_d[k].vld = (drop_q[k] > 0);
        cand2_d[k].key = signed'({{(KEY_W-SLOT_W){1'b0}}, wgt_q[k]});
      end else begin
        cand2_d[k].vld = 1'b1;
        cand2_d[k].key = score;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && v1_q) begin
      cand2_q    <= cand2_d;
      pre_sel2_q <= pre_sel_q;
      pre_dir2_q <= pre_dir_q;
      forced2_q  <= forced_q;
    end
  end

  // ---------------------------------------------------------------------
  // stage 3: first tree level, neighbour pairs
  // ---------------------------------------------------------------------
  d8fd_pkg::cand_t  cand3_d [NBR/2];
  d8fd_pkg::cand_t  cand3_q [NBR/2];
  logic             pre_sel3_q, forced3_q;
  logic [DIR_W-1:0] pre_dir3_q;

  for (genvar p = 0; p < NBR / 2; p++) begin : g_lvl1
    d8fd_pick u_pick (
      .a_i (cand2_q[2*p]),
      .b_i (cand2_q[2*p+1]),
      .y_o (cand3_d[p])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv3 && v2_q) begin
      cand3_q    <= cand3_d;
      pre_sel3_q <= pre_sel2_q;
      pre_dir3_q <= pre_dir2_q;
      forced3_q  <= forced2_q;
    end
  end

  // ---------------------------------------------------------------------
  // stage 4: last two tree levels and final selection into the output register
  // ---------------------------------------------------------------------
  d8fd_pkg::cand_t  cand_l2 [2];
  d8fd_pkg::cand_t  winner;
  logic [DIR_W-1:0] flow_dir_d, flow_dir_q;
  logic             was_forced_q;

  d8fd_pick u_pick_l2a (.a_i(cand3_q[0]), .b_i(cand3_q[1]), .y_o(cand_l2[0]));
  d8fd_pick u_pick_l2b (.a_i(cand3_q[2]), .b_i(cand3_q[3]), .y_o(cand_l2[1]));
  d8fd_pick u_pick_l3  (.a_i(cand_l2[0]), .b_i(cand_l2[1]), .y_o(winner));

  always_comb begin
    if (pre_sel3_q) begin
      flow_dir_d = pre_dir3_q;
    end else if (winner.vld) begin
      flow_dir_d = winner.dir;
    end else begin
      flow_dir_d = d8fd_pkg::DIR_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv4 && v3_q) begin
      flow_dir_q   <= flow_dir_d;
      was_forced_q <= forced3_q;
    end
  end

  assign out_valid_o  = v4_q;
  assign flow_dir_o   = flow_dir_q;
  assign was_forced_o = was_forced_q;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
`include "assert_macros.svh"

  `D8FD_ASSERT(a_dir_range, !out_valid_o || (flow_dir_o <= d8fd_pkg::DIR_LAST), "flow_dir out of range")
  `D8FD_ASSERT(a_forced_dir, !(out_valid_o && was_forced_o) || (flow_dir_o != d8fd_pkg::DIR_NONE), "forced result without direction")
  `D8FD_ASSERT(a_none_weighted, !(out_valid_o && (flow_dir_o == d8fd_pkg::DIR_NONE)) || (route_mode_q == d8fd_pkg::MODE_WEIGHT), "no direction in steepest mode")
  `D8FD_ASSERT_NEXT(a_stall_keeps, v3_q && !adv4, v3_q && v4_q, "item lost in a stalled stage")

endmodule

`default_nettype wire

@@ tb/d8_flow_direction_top_test.sv @@
// self-checking testbench for the d8 flow direction block
// depends on d8fd_pkg and d8_flow_direction_top; drives both handshakes and
// checks every result against a behavioural predictor of the drainage choice or a fixed verdict
`default_nettype none

module d8_flow_direction_top_test;

  // compass codes, odd ones are diagonals
  localparam logic [3:0] DIR_NE = 4'd1;
  localparam logic [3:0] DIR_E  = 4'd2;
  localparam logic [3:0] DIR_SE = 4'd3;
  localparam logic [3:0] DIR_S  = 4'd4;
  localparam logic [3:0] DIR_SW = 4'd5;
  localparam logic [3:0] DIR_W  = 4'd6;
  localparam logic [3:0] DIR_NW = 4'd7;
  localparam logic [3:0] DIR_N  = 4'd8;
  localparam logic [7:0] FORCED_NONE = 8'h00;

  // slope scaling in q16: orthogonal is 1.0, diagonal is 1/sqrt(2) rounded
  localparam longint ORTHO_Q16 = 65536;
  localparam longint DIAG_Q16  = 46341;

  localparam int HOLD_CYCLES     = 60;      // long receiver hold-off
  localparam int TAIL_CYCLES     = 8;       // pipeline is four deep
  localparam int LIMIT_CYCLES    = 200000;  // watchdog bound on the whole run
  localparam int ITEMS_PER_PHASE = 255;
  localparam int N_PHASES        = 6;
  localparam int N_ROWS          = 22;

  // one 3x3 window as it appears on the input ports
  typedef struct packed {
    logic [15:0] centre;
    logic [63:0] elev_lo;
    logic [63:0] elev_hi;
    logic [63:0] wt_lo;
    logic [63:0] wt_hi;
    logic [7:0]  grid;
    logic [7:0]  forced;
  } window_t;

  typedef struct packed {
    logic [3:0] dir;
    logic       forced_flag;
  } verdict_t;

  typedef struct packed {
    logic     mode;
    window_t  win;
    logic     typed;   // use the verdict below instead of the predictor
    verdict_t want;
  } row_t;

  // directed windows; neighbour k sits at bits 16((k-1)%4) of its word, so the
  // rightmost group of a literal is NE (lo) or SW (hi)
  localparam row_t DIRECTED [N_ROWS] = '{
    // flat window, steepest descent ties go to the earliest neighbour
    '{d8fd_pkg::MODE_STEEP, '{16'h0000, 64'h0, 64'h0, 64'h0, 64'h0, 8'hFF, FORCED_NONE},
      1'b1, '{DIR_NE, 1'b0}},
    // forced route at both ends of its range
    '{d8fd_pkg::MODE_STEEP, '{16'h0000, 64'h0, 64'h0, 64'h0, 64'h0, 8'hFF, 8'(DIR_NE)},
      1'b1, '{DIR_NE, 1'b1}},
    '{d8fd_pkg::MODE_STEEP, '{16'h1234, 64'h0, 64'h0, 64'h0, 64'h0, 8'h00, 8'(DIR_N)},
      1'b1, '{DIR_N, 1'b1}},
    // forced values outside 1..8 mean compute
    '{d8fd_pkg::MODE_STEEP, '{16'h0005, 64'h0007_0001_0009_0003,
      64'h0005_0002_0004_0006, 64'h0, 64'h0, 8'hFF, 8'd9},
      1'b0, '{d8fd_pkg::DIR_NONE, 1'b0}},
    '{d8fd_pkg::MODE_STEEP, '{16'h0005, 64'h0007_0001_0009_0003,
      64'h0005_0002_0004_0006, 64'h0, 64'h0, 8'hFF, 8'hFF},
      1'b0, '{d8fd_pkg::DIR_NONE, 1'b0}},
    // off-grid neighbours: first cleared bit wins outright
    '{d8fd_pkg::MODE_STEEP, '{16'h0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h0, 64'h0,
      8'h00, FORCED_NONE}, 1'b1, '{DIR_NE, 1'b0}},
    '{d8fd_pkg::MODE_STEEP, '{16'h0010, 64'h0, 64'h0, 64'h0, 64'h0, 8'h7F, FORCED_NONE},
      1'b1, '{DIR_N, 1'b0}},
    '{d8fd_pkg::MODE_STEEP, '{16'h0010, 64'h0, 64'h0, 64'h0, 64'h0, 8'hEF, FORCED_NONE},
      1'b1, '{DIR_SW, 1'b0}},
    // elevation extremes, largest drop and largest rise
    '{d8fd_pkg::MODE_STEEP, '{16'h7FFF, 64'h8000_8000_8000_8000,
      64'h8000_8000_8000_8000, 64'h0, 64'h0, 8'hFF, FORCED_NONE},
      1'b0, '{d8fd_pkg::DIR_NONE, 1'b0}},
    '{d8fd_pkg::MODE_STEEP, '{16'h8000, 64'h7FFF_7FFF_7FFF_7FFF,
      64'h7FFF_7FFF_7FFF_7FFF, 64'h0, 64'h0, 8'hFF, FORCED_NONE},
      1'b0, '{d8fd_pkg::DIR_NONE, 1'b0}},
    // equal drop: orthogonal beats diagonal
    '{d8fd_pkg::MODE_STEEP, '{16'h0001, 64'h0001_0001_0000_0000,
      64'h0001_0001_0001_0001, 64'h0, 64'h0, 8'hFF, FORCED_NONE},
      1'b0, '{d8fd_pkg::DIR_NONE, 1'b0}},
    // diagonal drop of two beats orthogonal drop of one
    '{d8fd_pkg::MODE_STEEP, '{16'h0002, 64'h0001_0000_0002_0002,
      64'h0002_0002_0002_0002, 64'h0, 64'h0, 8'hFF, FORCED_NONE},
      1'b0, '{d8fd_pkg::DIR_NONE, 1'b0}},
    // weights are ignored in steepest descent
    '{d8fd_pkg::MODE_STEEP, '{16'h0003, 64'h0004_0002_0003_0005,
      64'h0003_0001_0006_0003, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
      8'hFF, FORCED_NONE}, 1'b0, '{d8fd_pkg::DIR_NONE, 1'b0}},
    // weighted: nothing downslope gives no direction
    '{d8fd_pkg::MODE_WEIGHT, '{16'h0000, 64'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF,
      64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, FORCED_NONE}, 1'b1, '{d8fd_pkg::DIR_NONE, 1'b0}},
    '{d8fd_pkg::MODE_WEIGHT, '{16'h0000, 64'h0, 64'h0, 64'h0, 64'h0, 8'hFF, 8'(DIR_SE)},
      1'b1, '{DIR_SE, 1'b1}},
    '{d8fd_pkg::MODE_WEIGHT, '{16'h0000, 64'h0, 64'h0, 64'h0, 64'h0, 8'hFD, FORCED_NONE},
      1'b1, '{DIR_E, 1'b0}},
    // all downslope with equal weights, earliest stays
    '{d8fd_pkg::MODE_WEIGHT, '{16'h000A, 64'h0, 64'h0, 64'h0005_0005_0005_0005,
      64'h0005_0005_0005_0005, 8'hFF, FORCED_NONE}, 1'b0, '{d8fd_pkg::DIR_NONE, 1'b0}},
    // W and N share the top weight, W comes first
    '{d8fd_pkg::MODE_WEIGHT, '{16'h000A, 64'h0, 64'h0, 64'h0, 64'hFFFF_0000_FFFF_0000,
      8'hFF, FORCED_NONE}, 1'b0, '{d8fd_pkg::DIR_NONE, 1'b0}},
    // heavy uphill and flat neighbours lose to a light downslope one
    '{d8fd_pkg::MODE_WEIGHT, '{16'h0000, 64'h0000_0000_FFFF_0001, 64'h0,
      64'hFFFF_FFFF_0000_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, FORCED_NONE},
      1'b0, '{d8fd_pkg::DIR_NONE, 1'b0}},
    '{d8fd_pkg::MODE_WEIGHT, '{16'h7FFF, 64'h8000_8000_8000_8000,
      64'h8000_8000_8000_8000, 64'h0001_FFFF_0000_8000, 64'hFFFE_7FFF_FFFF_0003,
      8'hFF, 8'hF0}, 1'b0, '{d8fd_pkg::DIR_NONE, 1'b0}},
    '{d8fd_pkg::MODE_WEIGHT, '{16'h8000, 64'h7FFF_7FFF_7FFF_7FFF,
      64'h7FFF_7FFF_7FFF_7FFF, 64'h1111_2222_3333_4444, 64'h5555_6666_7777_8888,
      8'hFF, FORCED_NONE}, 1'b1, '{d8fd_pkg::DIR_NONE, 1'b0}},
    '{d8fd_pkg::MODE_WEIGHT, '{16'h0020, 64'h0030_0010_0025_001F,
      64'h0000_0021_0019_0040, 64'h0009_0004_0007_0002, 64'h0003_0008_0004_0001,
      8'hFF, 8'h10}, 1'b0, '{d8fd_pkg::DIR_NONE, 1'b0}}
  };

  // phase plan: mode and idle percentages of sender and receiver
  localparam logic PHASE_MODE [N_PHASES] = '{
    d8fd_pkg::MODE_STEEP, d8fd_pkg::MODE_WEIGHT, d8fd_pkg::MODE_WEIGHT,
    d8fd_pkg::MODE_STEEP, d8fd_pkg::MODE_STEEP, d8fd_pkg::MODE_WEIGHT
  };
  localparam int   PHASE_TX   [N_PHASES] = '{23, 23, 81, 81, 0, 0};
  localparam int   PHASE_RX   [N_PHASES] = '{81, 81, 23, 23, 0, 0};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] centre_elev = '0;
  logic [63:0] nbr_elev_lo = '0;
  logic [63:0] nbr_elev_hi = '0;
  logic [63:0] nbr_weight_lo = '0;
  logic [63:0] nbr_weight_hi = '0;
  logic [7:0]  nbr_in_grid = '0;
  logic [7:0]  forced_dir = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  flow_dir;
  logic        was_forced;

  logic     route_mode = d8fd_pkg::MODE_STEEP;  // shadow of the register
  verdict_t pending_dirs [$];         // predicted directions in transfer order
  int       mismatches = 0;
  int       tx_idle_pct = 0;
  int       rx_idle_pct = 0;
  int       hold_reqs = 0;            // bumped by the stimulus, seen by the receiver
  int       hold_seen = 0;
  int       hold_left = 0;
  int       cycles = 0;

  always #1 clk = ~clk;

  d8_flow_direction_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .center_elev_i   (centre_elev),
    .nbr_elev_lo_i   (nbr_elev_lo),
    .nbr_elev_hi_i   (nbr_elev_hi),
    .nbr_weight_lo_i (nbr_weight_lo),
    .nbr_weight_hi_i (nbr_weight_hi),
    .nbr_in_grid_i   (nbr_in_grid),
    .forced_dir_i    (forced_dir),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .flow_dir_o      (flow_dir),
    .was_forced_o    (was_forced)
  );

  // 16-bit slot of neighbour k within its half-word group
  function automatic logic [15:0] lane(input logic [63:0] word, input int k);
    return word[16*((k-1)%4) +: 16];
  endfunction

  // drainage choice for one window under the given routing mode
  function automatic verdict_t predict_route(input window_t w, input logic mode);
    verdict_t v;
    logic [3:0] best;
    longint     slope;
    longint     best_slope;
    int         zc;
    int         zn;
    int         drop;
    int         wt;
    int         best_wt;
    int         k;
    bit         settled;
    v = '{d8fd_pkg::DIR_NONE, 1'b0};
    if (w.forced >= d8fd_pkg::DIR_FIRST && w.forced <= d8fd_pkg::DIR_LAST) begin
      v.dir = w.forced[3:0];
      v.forced_flag = 1'b1;
      return v;
    end
    best = d8fd_pkg::DIR_NONE;
    best_slope = 0;
    best_wt = 0;
    settled = 1'b0;
    zc = $signed(w.centre);
    for (k = 1; k <= d8fd_pkg::NBR; k++) begin
      if (!settled) begin
        if (!w.grid[k-1]) begin
          // off the grid: drain straight out of it
          best = 4'(k);
          settled = 1'b1;
        end else begin
          zn = $signed(lane((k <= 4) ? w.elev_lo : w.elev_hi, k));
          wt = int'(lane((k <= 4) ? w.wt_lo : w.wt_hi, k));
          drop = zc - zn;
          slope = longint'(drop) * ((k % 2 == 1) ? DIAG_Q16 : ORTHO_Q16);
          if (mode == d8fd_pkg::MODE_STEEP) begin
            if (best == d8fd_pkg::DIR_NONE || best_slope < slope) begin
              best = 4'(k);
              best_slope = slope;
            end
          end else if (drop > 0) begin
            if (best == d8fd_pkg::DIR_NONE || best_wt < wt) begin
              best = 4'(k);
              best_wt = wt;
            end
          end
        end
      end
    end
    v.dir = best;
    return v;
  endfunction

  // windows that mostly reach the slope comparison, with noisy extras
  function automatic window_t random_window();
    window_t     w;
    logic [15:0] e;
    logic [15:0] wt;
    int          pick;
    int          k;
    pick = $urandom_range(9);
    w.centre = (pick == 0) ? 16'h8000 : (pick == 1) ? 16'h7FFF : 16'($urandom);
    for (k = 1; k <= d8fd_pkg::NBR; k++) begin
      pick = $urandom_range(9);
      if (pick < 6)
        e = w.centre + 16'($urandom_range(6)) - 16'd3;  // near ties and small drops
      else if (pick < 9)
        e = 16'($urandom);
      else
        e = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
      pick = $urandom_range(9);
      if (pick < 5)
        wt = 16'($urandom_range(3));  // small weights force ties
      else if (pick < 8)
        wt = 16'($urandom);
      else
        wt = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      if (k <= 4) begin
        w.elev_lo[16*(k-1) +: 16] = e;
        w.wt_lo[16*(k-1) +: 16] = wt;
      end else begin
        w.elev_hi[16*(k-5) +: 16] = e;
        w.wt_hi[16*(k-5) +: 16] = wt;
      end
    end
    pick = $urandom_range(9);
    w.grid = (pick < 8) ? 8'hFF : 8'($urandom);
    pick = $urandom_range(9);
    if (pick < 7)
      w.forced = FORCED_NONE;
    else if (pick < 8)
      w.forced = 8'($urandom_range(255, 9));
    else
      w.forced = 8'($urandom_range(d8fd_pkg::DIR_LAST, d8fd_pkg::DIR_FIRST));
    return w;
  endfunction

  // offer one window and hold it until the transfer; valid stays high after
  task automatic offer(input window_t w, input logic typed, input verdict_t want);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid      <= 1'b1;
    centre_elev   <= w.centre;
    nbr_elev_lo   <= w.elev_lo;
    nbr_elev_hi   <= w.elev_hi;
    nbr_weight_lo <= w.wt_lo;
    nbr_weight_hi <= w.wt_hi;
    nbr_in_grid   <= w.grid;
    forced_dir    <= w.forced;
    do @(posedge clk); while (!in_ready);
    pending_dirs.push_back(typed ? want : predict_route(w, route_mode));
  endtask

  // drop valid and wait for every outstanding result
  task automatic await_results();
    in_valid <= 1'b0;
    while (pending_dirs.size() != 0) @(posedge clk);
  endtask

  // register write with the pipeline empty; every item yields a result
  task automatic set_route_mode(input logic mode);
    await_results();
    cfg_we   <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    cfg_we     <= 1'b0;
    route_mode = mode;
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // result checker, oldest prediction first
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_dirs.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("unexpected transfer: flow_dir %0d was_forced %0d", flow_dir, was_forced);
      end else begin
        want = pending_dirs.pop_front();
        if (flow_dir !== want.dir || was_forced !== want.forced_flag) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("mismatch: flow_dir exp %0d got %0d, was_forced exp %0d got %0d",
                     want.dir, flow_dir, want.forced_flag, was_forced);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int p;
    int i;
    int r;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed windows under the first idle pattern
    tx_idle_pct = PHASE_TX[0];
    rx_idle_pct = PHASE_RX[0];
    for (r = 0; r < N_ROWS; r++) begin
      if (DIRECTED[r].mode != route_mode)
        set_route_mode(DIRECTED[r].mode);
      offer(DIRECTED[r].win, DIRECTED[r].typed, DIRECTED[r].want);
    end

    // random windows, one routing mode and idle pattern per phase
    for (p = 0; p < N_PHASES; p++) begin
      set_route_mode(PHASE_MODE[p]);
      tx_idle_pct = PHASE_TX[p];
      rx_idle_pct = PHASE_RX[p];
      // with no idling, a long receiver hold-off backs the pipeline up
      if (p == 4)
        hold_reqs = hold_reqs + 1;
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        // sender pause until the pipeline has fully drained
        if (p == 2 && i == ITEMS_PER_PHASE / 2)
          await_results();
        offer(random_window(), 1'b0, '0);
      end
    end

    await_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+rtl
rtl/d8fd_pkg.sv
rtl/d8fd_pick.sv
rtl/d8_flow_direction_top.sv
tb/d8_flow_direction_top_test.sv
